// File: rtl/core/drtq_pkg.sv
// Shared types and constants for the de-duplicating ring task queue.
package drtq_pkg;

  localparam int unsigned ID_W  = 8;
  localparam int unsigned TAG_W = 32;

  typedef enum logic [1:0] {
    FUNC_ENQ   = 2'd0,
    FUNC_DEQ   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } drtq_func_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_EMPTY = 2'd3
  } drtq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_WRITE,
    S_HREAD,
    S_FIN
  } drtq_state_t;

  typedef struct packed {
    drtq_func_t        func;
    logic [ID_W-1:0]   task_id;
    logic [TAG_W-1:0]  data1_tag;
    logic [TAG_W-1:0]  data2_tag;
  } drtq_in_t;

  typedef struct packed {
    drtq_status_t      status;
    logic              entry_valid;
    logic [ID_W-1:0]   head_task_id;
    logic [TAG_W-1:0]  head_data1;
    logic [TAG_W-1:0]  head_data2;
    logic              now_empty;
  } drtq_out_t;

  // controller -> datapath
  typedef struct packed {
    logic         load;       // capture input beat, scan pointer from head
    logic         rd_first;   // read slot at scan pointer
    logic         scan_step;  // advance scan pointer and read next slot
    logic         tail_wr;    // write entry at tail, advance tail
    logic         head_inc;   // pop head
    logic         head_clr;   // head takes tail
    logic         post;       // load output register
    drtq_status_t code;
    logic         entry;
  } drtq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    drtq_func_t func;
    logic       empty;
    logic       full;
    logic       id_match;
    logic       scan_last;
    logic       out_free;
  } drtq_stat_t;

endpackage

// File: rtl/core/dedup_ring_task_queue.sv
// Top level of the ring task queue with duplicate suppression.
//
//  beat     ports                          payload
//  -------  -----------------------------  -----------------------------------
//  request  in_valid / in_ready            in_data  : func, task_id, tags
//  result   out_valid / out_ready          out_data : status, head entry, empty
//
// One request is in flight at a time; each gives exactly one result beat.
// Enqueue time is set by the duplicate scan, which reads one stored id a cycle
// through the slot RAM port.
// Dequeue and peek pass through a head read step before posting; clear and a
// full or empty rejection post straight after decode. A duplicate ends the
// scan at the matching slot.
// A result waiting on out_ready does not stop the next request being taken;
// that request only holds in its last step until the result register frees.
// Synchronous reset empties the queue; slot contents are not cleared.
module dedup_ring_task_queue #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned TAG_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  drtq_pkg::drtq_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output drtq_pkg::drtq_out_t out_data
);

  drtq_pkg::drtq_cmd_t  cmd;
  drtq_pkg::drtq_stat_t stat;

  drtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  drtq_dp #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/core/drtq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module drtq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/drtq_ctrl.sv
// Sequencing state machine for the task queue.
module drtq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  drtq_pkg::drtq_stat_t stat,
  output drtq_pkg::drtq_cmd_t  cmd
);

  drtq_pkg::drtq_state_t  state_r, state_nxt;
  drtq_pkg::drtq_status_t code_r, code_nxt;
  logic                   entry_r, entry_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drtq_pkg::S_IDLE;
      code_r  <= drtq_pkg::ST_DONE;
      entry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      entry_r <= entry_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    entry_nxt = entry_r;
    cmd       = '0;
    cmd.code  = code_r;
    cmd.entry = entry_r;
    in_ready  = 1'b0;
    case (state_r)
      drtq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          code_nxt  = drtq_pkg::ST_DONE;
          entry_nxt = 1'b0;
          state_nxt = drtq_pkg::S_DECODE;
        end
      end
      drtq_pkg::S_DECODE: begin
        case (stat.func)
          drtq_pkg::FUNC_ENQ: begin
            if (stat.full) begin
              code_nxt  = drtq_pkg::ST_FULL;
              state_nxt = drtq_pkg::S_FIN;
            end else if (stat.empty) begin
              state_nxt = drtq_pkg::S_WRITE;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = drtq_pkg::S_SCAN;
            end
          end
          drtq_pkg::FUNC_DEQ, drtq_pkg::FUNC_PEEK: begin
            if (stat.empty) begin
              code_nxt  = drtq_pkg::ST_EMPTY;
              state_nxt = drtq_pkg::S_FIN;
            end else begin
              cmd.rd_first = 1'b1;
              state_nxt    = drtq_pkg::S_HREAD;
            end
          end
          drtq_pkg::FUNC_CLEAR: begin
            cmd.head_clr = 1'b1;
            state_nxt    = drtq_pkg::S_FIN;
          end
          default: begin
            state_nxt = drtq_pkg::S_FIN;
          end
        endcase
      end
      drtq_pkg::S_SCAN: begin
        if (stat.id_match) begin
          code_nxt  = drtq_pkg::ST_DUP;
          state_nxt = drtq_pkg::S_FIN;
        end else if (stat.scan_last) begin
          state_nxt = drtq_pkg::S_WRITE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      drtq_pkg::S_WRITE: begin
        cmd.tail_wr = 1'b1;
        state_nxt   = drtq_pkg::S_FIN;
      end
      drtq_pkg::S_HREAD: begin
        // read data of head slot is in the RAM output now
        cmd.head_inc = (stat.func == drtq_pkg::FUNC_DEQ);
        entry_nxt    = 1'b1;
        state_nxt    = drtq_pkg::S_FIN;
      end
      drtq_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.post  = 1'b1;
          state_nxt = drtq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = drtq_pkg::S_IDLE;
      end
    endcase
  end

  a_entry_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post && cmd.entry |-> cmd.code == drtq_pkg::ST_DONE)
    else $error("head entry posted with a failure status");

  a_post_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.post |-> stat.out_free)
    else $error("result posted over an untaken beat");

  a_write_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tail_wr |-> $past(state_r) == drtq_pkg::S_DECODE ||
                    ($past(state_r) == drtq_pkg::S_SCAN && !$past(stat.id_match)))
    else $error("enqueue written without a clean duplicate scan");

endmodule

// File: rtl/core/drtq_dp.sv
// Queue pointers, slot storage, duplicate compare and result register.
module drtq_dp #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned TAG_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  drtq_pkg::drtq_in_t  in_data,
  input  drtq_pkg::drtq_cmd_t cmd,
  output drtq_pkg::drtq_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output drtq_pkg::drtq_out_t out_data
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = (TAG_WIDTH < drtq_pkg::TAG_W) ? TAG_WIDTH : drtq_pkg::TAG_W;
  localparam int unsigned EW = drtq_pkg::ID_W + 2 * SW;

  drtq_pkg::drtq_in_t  item_r;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [AW-1:0]       scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;
  drtq_pkg::drtq_out_t out_r;

  logic [EW-1:0]       wdata, rdata;
  logic [AW-1:0]       raddr;
  logic                re;
  logic [drtq_pkg::ID_W-1:0] rd_id;
  logic [SW-1:0]       rd_t1, rd_t2;
  logic                empty, full;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  assign empty = (head_r == tail_r);
  assign full  = (head_r == wrap_inc(tail_r));

  assign {rd_id, rd_t1, rd_t2} = rdata;
  assign wdata = {item_r.task_id, item_r.data1_tag[SW-1:0], item_r.data2_tag[SW-1:0]};

  assign scan_nxt = cmd.load ? head_r : (cmd.scan_step ? wrap_inc(scan_r) : scan_r);
  assign re       = cmd.rd_first | cmd.scan_step;
  assign raddr    = cmd.scan_step ? wrap_inc(scan_r) : scan_r;

  drtq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.tail_wr),
    .waddr (tail_r),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    head_nxt = head_r;
    if (cmd.head_clr) begin
      head_nxt = tail_r;
    end else if (cmd.head_inc) begin
      head_nxt = wrap_inc(head_r);
    end
  end

  assign tail_nxt      = cmd.tail_wr ? wrap_inc(tail_r) : tail_r;
  assign out_valid_nxt = cmd.post ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.post) begin
      out_r.status       <= cmd.code;
      out_r.entry_valid  <= cmd.entry;
      out_r.head_task_id <= cmd.entry ? rd_id : '0;
      out_r.head_data1   <= cmd.entry ? drtq_pkg::TAG_W'(rd_t1) : '0;
      out_r.head_data2   <= cmd.entry ? drtq_pkg::TAG_W'(rd_t2) : '0;
      out_r.now_empty    <= empty;
    end
  end

  assign stat.func      = item_r.func;
  assign stat.empty     = empty;
  assign stat.full      = full;
  assign stat.id_match  = (rd_id == item_r.task_id);
  assign stat.scan_last = (wrap_inc(scan_r) == tail_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(empty && full))
    else $error("queue pointers report full and empty together");

  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tail_wr |-> !full)
    else $error("slot written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.head_inc |-> !empty && !cmd.head_clr)
    else $error("head popped from an empty queue");

endmodule

// File: bench/tb_dedup_ring_task_queue.sv
// Self-checking bench for the ring task queue with duplicate suppression.
module tb_dedup_ring_task_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QDEPTH      = 256;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int IDW         = drtq_pkg::ID_W;
  localparam int TW          = drtq_pkg::TAG_W;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  drtq_pkg::drtq_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  drtq_pkg::drtq_out_t out_data;

  dedup_ring_task_queue #(
    .DEPTH     (QDEPTH),
    .TAG_WIDTH (TW)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // queue mirror
  logic [IDW-1:0] mirror_id [QDEPTH];
  logic [TW-1:0]  mirror_d1 [QDEPTH];
  logic [TW-1:0]  mirror_d2 [QDEPTH];
  int             mirror_head = 0;
  int             mirror_tail = 0;

  drtq_pkg::drtq_out_t pending_results[$];
  int        fail_count     = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct  = 0;
  int        hold_requests   = 0;
  int        hold_served     = 0;
  int        hold_left       = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int ring_next(input int idx);
    return (idx + 1) % QDEPTH;
  endfunction

  function automatic int queue_occupancy();
    return (mirror_tail - mirror_head + QDEPTH) % QDEPTH;
  endfunction

  function automatic drtq_pkg::drtq_out_t predict_queue_op(input drtq_pkg::drtq_in_t req);
    drtq_pkg::drtq_out_t r;
    int        idx;
    bit        dup;
    r = '0;
    r.status = drtq_pkg::ST_DONE;
    case (req.func)
      drtq_pkg::FUNC_ENQ: begin
        if (ring_next(mirror_tail) == mirror_head) begin
          r.status = drtq_pkg::ST_FULL;
        end else begin
          dup = 1'b0;
          for (idx = mirror_head; idx != mirror_tail; idx = ring_next(idx))
            if (mirror_id[idx] == req.task_id) dup = 1'b1;
          if (dup) begin
            r.status = drtq_pkg::ST_DUP;
          end else begin
            mirror_id[mirror_tail] = req.task_id;
            mirror_d1[mirror_tail] = req.data1_tag;
            mirror_d2[mirror_tail] = req.data2_tag;
            mirror_tail = ring_next(mirror_tail);
          end
        end
      end
      drtq_pkg::FUNC_DEQ, drtq_pkg::FUNC_PEEK: begin
        if (mirror_head == mirror_tail) begin
          r.status = drtq_pkg::ST_EMPTY;
        end else begin
          r.entry_valid  = 1'b1;
          r.head_task_id = mirror_id[mirror_head];
          r.head_data1   = mirror_d1[mirror_head];
          r.head_data2   = mirror_d2[mirror_head];
          if (req.func == drtq_pkg::FUNC_DEQ) mirror_head = ring_next(mirror_head);
        end
      end
      default: begin
        mirror_head = mirror_tail;
      end
    endcase
    r.now_empty = (mirror_head == mirror_tail);
    return r;
  endfunction

  function automatic drtq_pkg::drtq_in_t mk_req(input drtq_pkg::drtq_func_t f,
                                                input logic [IDW-1:0] id,
                                                input logic [TW-1:0] d1,
                                                input logic [TW-1:0] d2);
    drtq_pkg::drtq_in_t r;
    r.func      = f;
    r.task_id   = id;
    r.data1_tag = d1;
    r.data2_tag = d2;
    return r;
  endfunction

  task automatic send_item(input drtq_pkg::drtq_in_t req);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_queue_op(req));
  endtask

  task automatic compare_field(input string name, input logic [TW-1:0] exp_v,
                               input logic [TW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  task automatic check_result();
    drtq_pkg::drtq_out_t exp_r;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing expected: %p", out_data);
      fail_count++;
      return;
    end
    exp_r = pending_results.pop_front();
    compare_field("status",       TW'(exp_r.status),       TW'(out_data.status));
    compare_field("entry_valid",  TW'(exp_r.entry_valid),  TW'(out_data.entry_valid));
    compare_field("head_task_id", TW'(exp_r.head_task_id), TW'(out_data.head_task_id));
    compare_field("head_data1",   exp_r.head_data1,        out_data.head_data1);
    compare_field("head_data2",   exp_r.head_data2,        out_data.head_data2);
    compare_field("now_empty",    TW'(exp_r.now_empty),    TW'(out_data.now_empty));
  endtask

  // result side: check, then pick next ready; a hold request forces a long stall
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_item(mk_req(drtq_pkg::FUNC_PEEK,  8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'h00, 32'h1111_1111, 32'h2222_2222));  // dup at head
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'hFF, 32'h3333_3333, 32'h4444_4444));  // dup at tail
    send_item(mk_req(drtq_pkg::FUNC_PEEK,  8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'h00, 32'hAAAA_AAAA, 32'h5555_5555));  // gone
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'hFF, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'h5A, 32'h5555_5555, 32'hAAAA_AAAA));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'hA5, 32'h1234_5678, 32'h9ABC_DEF0));
    send_item(mk_req(drtq_pkg::FUNC_CLEAR, 8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_PEEK,  8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,   8'h5A, 32'hDEAD_BEEF, 32'hCAFE_F00D));  // cleared
    send_item(mk_req(drtq_pkg::FUNC_PEEK,  8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,   8'h00, 32'h0, 32'h0));
  endtask

  // fill to DEPTH-1 entries; indices wrap as earlier beats moved them on
  task automatic test_full_queue();
    int k;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_item(mk_req(drtq_pkg::FUNC_CLEAR, 8'h00, 32'h0, 32'h0));
    for (k = 0; k < QDEPTH - 1; k++)
      send_item(mk_req(drtq_pkg::FUNC_ENQ, k[IDW-1:0], $urandom, $urandom));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,  8'hFF, $urandom, $urandom));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,  8'h03, $urandom, $urandom));  // full beats duplicate
    send_item(mk_req(drtq_pkg::FUNC_PEEK, 8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,  8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_DEQ,  8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,  8'hFE, $urandom, $urandom));  // dup near the tail
    send_item(mk_req(drtq_pkg::FUNC_ENQ,  8'h00, $urandom, $urandom));
    send_item(mk_req(drtq_pkg::FUNC_ENQ,  8'h01, $urandom, $urandom));  // full again
    // drain a few under receiver stalls, then clear the rest
    recv_stall_pct = 67;
    for (k = 0; k < 8; k++)
      send_item(mk_req(drtq_pkg::FUNC_DEQ, 8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_CLEAR, 8'h00, 32'h0, 32'h0));
    send_item(mk_req(drtq_pkg::FUNC_PEEK, 8'h00, 32'h0, 32'h0));
  endtask

  task automatic test_pressure();
    int k;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_requests++;
    for (k = 0; k < 12; k++)
      send_item(mk_req(k % 3 == 2 ? drtq_pkg::FUNC_DEQ : drtq_pkg::FUNC_ENQ,
                       IDW'($urandom_range(0, 7)), $urandom, $urandom));
  endtask

  task automatic test_random();
    int          idle_sched[4]  = '{0, 67, 0, 32};
    int          stall_sched[4] = '{0, 0, 67, 32};
    int          phase;
    int          n;
    int          pick;
    int          target;
    logic [7:0]  id;
    drtq_pkg::drtq_func_t f;
    target = 4;
    for (phase = 0; phase < 4; phase++) begin
      sender_idle_pct = idle_sched[phase];
      recv_stall_pct  = stall_sched[phase];
      for (n = 0; n < 60; n++) begin
        if (n % 30 == 0)
          target = ($urandom_range(99) < 80) ? $urandom_range(0, 8) : $urandom_range(20, 60);
        pick = $urandom_range(99);
        if (pick < 4)
          f = drtq_pkg::FUNC_CLEAR;
        else if (pick < 18)
          f = drtq_pkg::FUNC_PEEK;
        else if (queue_occupancy() < target)
          f = ($urandom_range(99) < 75) ? drtq_pkg::FUNC_ENQ : drtq_pkg::FUNC_DEQ;
        else
          f = ($urandom_range(99) < 25) ? drtq_pkg::FUNC_ENQ : drtq_pkg::FUNC_DEQ;
        // small id pool keeps duplicates frequent
        id = ($urandom_range(99) < 60) ? IDW'($urandom_range(0, 15))
                                       : IDW'($urandom_range(0, 255));
        send_item(mk_req(f, id, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_queue();
    test_pressure();
    test_random();

    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
